@@ hw/rtl/u16u8_pkg.sv @@
// Shared types, constants and UTF-8 encoding functions for the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

  localparam int unsigned CapW      = 21;
  localparam int unsigned CpW       = 21;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam logic [CapW-1:0] CapReset = 21'd256;
  localparam logic [5:0] HighTag    = 6'b110110;
  localparam logic [5:0] LowTag     = 6'b110111;

  typedef struct packed {
    logic            a_valid;
    logic [CpW-1:0]  cp_a;
    logic            b_valid;
    logic [15:0]     cp_b;
    logic            term;
  } entry_t;

  function automatic logic [2:0] utf8_len(input logic [CpW-1:0] u);
    logic [2:0] n;
    if (u < 21'h80) begin
      n = 3'd1;
    end else if (u < 21'h800) begin
      n = 3'd2;
    end else if (u < 21'h10000) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CpW-1:0] u, input logic [2:0] n,
                                           input logic [1:0] k);
    logic [7:0] b;
    b = 8'h00;
    unique case (n)
      3'd1: b = {1'b0, u[6:0]};
      3'd2: begin
        unique case (k)
          2'd0:    b = {3'b110, u[10:6]};
          default: b = {2'b10, u[5:0]};
        endcase
      end
      3'd3: begin
        unique case (k)
          2'd0:    b = {4'b1110, u[15:12]};
          2'd1:    b = {2'b10, u[11:6]};
          default: b = {2'b10, u[5:0]};
        endcase
      end
      3'd4: begin
        unique case (k)
          2'd0: b = {5'b11110, u[20:18]};
          2'd1: b = {2'b10, u[17:12]};
          2'd2: b = {2'b10, u[11:6]};
          2'd3: b = {2'b10, u[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/u16u8_front.sv @@
// Front end: accepts code units, pairs surrogates, tracks capacity and issues encode entries.
module u16u8_front import u16u8_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cap_we_i,
  input  logic [CapW-1:0] cap_wdata_i,
  input  logic            accept_i,
  input  logic [15:0]     code_unit_i,
  input  logic            unit_valid_i,
  input  logic            end_of_string_i,
  output logic            q_push_o,
  output entry_t          q_entry_o
);

  logic [CapW-1:0] cap_q, cap_d;
  logic [CapW-1:0] bw_q, bw_d;
  logic            halted_q, halted_d;
  logic            held_q, held_d;
  logic [9:0]      held_bits_q, held_bits_d;

  logic            do_unit, is_low, is_high, pair, flush_a, unit_rest, room;
  logic            halt_now, hold_now, enc_cu, held_after, eos_flush;
  logic [9:0]      bits_after;
  logic [CapW-1:0] bw1, bw2;
  logic [2:0]      a_len, cu_len;
  entry_t          entry;

  always_comb begin
    do_unit   = unit_valid_i && !halted_q;
    is_low    = code_unit_i[15:10] == LowTag;
    is_high   = code_unit_i[15:10] == HighTag;
    pair      = do_unit && held_q && is_low;
    flush_a   = do_unit && held_q && !is_low;
    a_len     = pair ? 3'd4 : (flush_a ? 3'd3 : 3'd0);
    bw1       = bw_q + CapW'(a_len);
    room      = ({1'b0, bw1} + (CapW+1)'(4)) < {1'b0, cap_q};
    unit_rest = do_unit && !pair;
    halt_now  = unit_rest && !room;
    hold_now  = unit_rest && room && is_high;
    enc_cu    = unit_rest && room && !is_high;
    cu_len    = enc_cu ? utf8_len({5'b0, code_unit_i}) : 3'd0;
    bw2       = bw1 + CapW'(cu_len);

    if (hold_now) begin
      held_after = 1'b1;
    end else if (pair || flush_a) begin
      held_after = 1'b0;
    end else begin
      held_after = held_q;
    end
    bits_after = hold_now ? code_unit_i[9:0] : held_bits_q;
    eos_flush  = end_of_string_i && held_after;

    entry.a_valid = pair || flush_a;
    entry.cp_a    = pair ? (CpW'(21'h10000) + {1'b0, held_bits_q, code_unit_i[9:0]})
                         : {5'b0, HighTag, held_bits_q};
    entry.b_valid = enc_cu || eos_flush;
    entry.cp_b    = enc_cu ? code_unit_i : {HighTag, bits_after};
    entry.term    = end_of_string_i;
  end

  assign q_entry_o = entry;
  assign q_push_o  = accept_i && (entry.a_valid || entry.b_valid || entry.term);

  always_comb begin
    cap_d       = cap_we_i ? cap_wdata_i : cap_q;
    bw_d        = bw_q;
    halted_d    = halted_q;
    held_d      = held_q;
    held_bits_d = held_bits_q;
    if (accept_i) begin
      if (end_of_string_i) begin
        bw_d        = '0;
        halted_d    = 1'b0;
        held_d      = 1'b0;
        held_bits_d = '0;
      end else begin
        bw_d        = bw2;
        halted_d    = halted_q || halt_now;
        held_d      = held_after;
        held_bits_d = bits_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      bw_q        <= '0;
      halted_q    <= 1'b0;
      held_q      <= 1'b0;
      held_bits_q <= '0;
    end else begin
      cap_q       <= cap_d;
      bw_q        <= bw_d;
      halted_q    <= halted_d;
      held_q      <= held_d;
      held_bits_q <= held_bits_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_hold_when_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(held_q && halted_q))
    else $error("surrogate held while string is halted");
  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_string_i |=> !held_q && !halted_q && bw_q == '0)
    else $error("end of string did not clear state");
`endif

endmodule

@@ hw/rtl/u16u8_fifo.sv @@
// Small flop-based queue of encode entries between the front and back ends.
module u16u8_fifo import u16u8_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   empty_o
);

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + QPtrW'(1) : wptr_q;
    rptr_d = pop_i ? rptr_q + QPtrW'(1) : rptr_q;
    cnt_d  = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("entry queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("entry queue underflow");
`endif

endmodule

@@ hw/rtl/u16u8_back.sv @@
// Back end: expands each encode entry into UTF-8 bytes and holds them in an output register.
module u16u8_back import u16u8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  entry_t     q_entry_i,
  output logic       q_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic            busy_q, busy_d;
  logic [CpW-1:0]  cp_a_q;
  logic [15:0]     cp_b_q;
  logic [2:0]      la_q, lb_q, total_q, pos_q, pos_d;
  logic [2:0]      la_n, lb_n, pos_b;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, byte_d;
  logic            last_q, last_d;
  logic            adv, finishing, load, out_taken;

  always_comb begin
    out_taken = pop_i && out_valid_q;
    adv       = busy_q && (!out_valid_q || out_taken);
    finishing = adv && (pos_q == total_q - 3'd1);
    load      = !q_empty_i && (!busy_q || finishing);
    la_n      = q_entry_i.a_valid ? utf8_len(q_entry_i.cp_a) : 3'd0;
    lb_n      = q_entry_i.b_valid ? utf8_len({5'b0, q_entry_i.cp_b}) : 3'd0;
    pos_b     = pos_q - la_q;

    if (pos_q < la_q) begin
      byte_d = utf8_byte(cp_a_q, la_q, pos_q[1:0]);
      last_d = 1'b0;
    end else if (pos_q < la_q + lb_q) begin
      byte_d = utf8_byte({5'b0, cp_b_q}, lb_q, pos_b[1:0]);
      last_d = 1'b0;
    end else begin
      byte_d = 8'h00;
      last_d = 1'b1;
    end

    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_taken) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    if (load) begin
      busy_d = 1'b1;
      pos_d  = '0;
    end else if (finishing) begin
      busy_d = 1'b0;
      pos_d  = '0;
    end else begin
      busy_d = busy_q;
      pos_d  = adv ? pos_q + 3'd1 : pos_q;
    end
  end

  assign q_pop_o    = load;
  assign empty_o    = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign last_o     = last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_a_q  <= q_entry_i.cp_a;
      cp_b_q  <= q_entry_i.cp_b;
      la_q    <= la_n;
      lb_q    <= lb_n;
      total_q <= la_n + lb_n + 3'(q_entry_i.term);
    end
    if (adv) begin
      out_byte_q <= byte_d;
      last_q     <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q < total_q)
    else $error("byte position beyond entry length");
`endif

endmodule

@@ hw/rtl/utf16_to_utf8_transcoder_top.sv @@
// Top level of the UTF-16 to UTF-8 transcoder.
// Code units are taken at one item per cycle while the four-entry entry queue has room;
// the front end pairs surrogates and applies the capacity limit in the cycle of acceptance.
// UTF-8 bytes leave one per cycle from the back end while pop is held, and an item yields as many
// bytes as it encodes: zero to seven, typically one to three, including the zero terminator with
// last set at the end of each string. out_capacity_i is written while out_capacity_we_i is high
// and takes effect at the next capacity check; its reset value is 256.
module utf16_to_utf8_transcoder_top import u16u8_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            out_capacity_we_i,
  input  logic [CapW-1:0] out_capacity_i,
  input  logic            push,
  output logic            full,
  input  logic [15:0]     code_unit_i,
  input  logic            unit_valid_i,
  input  logic            end_of_string_i,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wdata, q_rdata;

  assign full = q_full;

  u16u8_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cap_we_i        (out_capacity_we_i),
    .cap_wdata_i     (out_capacity_i),
    .accept_i        (push && !q_full),
    .code_unit_i     (code_unit_i),
    .unit_valid_i    (unit_valid_i),
    .end_of_string_i (end_of_string_i),
    .q_push_o        (q_push),
    .q_entry_o       (q_wdata)
  );

  u16u8_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  u16u8_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_entry_i  (q_rdata),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

@@ bench/tb_utf16_to_utf8_transcoder_top.sv @@
// Self-checking testbench for the UTF-16 to UTF-8 transcoder, with its own byte predictor.
module tb_utf16_to_utf8_transcoder_top import u16u8_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 16;

  typedef struct packed {
    logic [15:0] unit;
    logic        valid;
    logic        eos;
  } unit_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       term;
  } utf8_byte_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            out_capacity_we_i = 1'b0;
  logic [CapW-1:0] out_capacity_i = '0;
  logic            push = 1'b0;
  logic            full;
  logic [15:0]     code_unit_i = '0;
  logic            unit_valid_i = 1'b0;
  logic            end_of_string_i = 1'b0;
  logic            pop = 1'b0;
  logic            empty;
  logic [7:0]      out_byte_o;
  logic            last_o;

  unit_item_t  pending_units[$];
  utf8_byte_t  utf8_expected[$];
  int unsigned units_made;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_gap;
  int unsigned take_stall;
  logic        took;
  logic        steady;

  logic [CapW-1:0] cap_model;
  logic [9:0]      held_bits;
  logic            held;
  logic [CapW-1:0] written;
  logic            stopped;

  utf16_to_utf8_transcoder_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .out_capacity_we_i (out_capacity_we_i),
    .out_capacity_i    (out_capacity_i),
    .push              (push),
    .full              (full),
    .code_unit_i       (code_unit_i),
    .unit_valid_i      (unit_valid_i),
    .end_of_string_i   (end_of_string_i),
    .pop               (pop),
    .empty             (empty),
    .out_byte_o        (out_byte_o),
    .last_o            (last_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic void emit(input int unsigned b, input logic term);
    utf8_byte_t e;
    e.value = 8'(b);
    e.term  = term;
    utf8_expected.push_back(e);
  endfunction

  function automatic void encode_point(input int unsigned u);
    if (u < 32'h80) begin
      emit(u, 1'b0);
      written = written + CapW'(1);
    end else if (u < 32'h800) begin
      emit(32'hC0 | (u >> 6), 1'b0);
      emit(32'h80 | (u & 32'h3F), 1'b0);
      written = written + CapW'(2);
    end else if (u < 32'h10000) begin
      emit(32'hE0 | (u >> 12), 1'b0);
      emit(32'h80 | ((u >> 6) & 32'h3F), 1'b0);
      emit(32'h80 | (u & 32'h3F), 1'b0);
      written = written + CapW'(3);
    end else begin
      emit(32'hF0 | (u >> 18), 1'b0);
      emit(32'h80 | ((u >> 12) & 32'h3F), 1'b0);
      emit(32'h80 | ((u >> 6) & 32'h3F), 1'b0);
      emit(32'h80 | (u & 32'h3F), 1'b0);
      written = written + CapW'(4);
    end
  endfunction

  function automatic void flush_held();
    if (held) begin
      held = 1'b0;
      encode_point({16'd0, HighFirst} | {22'd0, held_bits});
    end
  endfunction

  function automatic void transcode(input unit_item_t it);
    logic is_low;
    int unsigned pair;
    if (it.valid && !stopped) begin
      is_low = it.unit >= LowFirst && it.unit <= LowLast;
      if (held && is_low) begin
        pair = 32'h10000 + ({22'd0, held_bits} << 10) + ({16'd0, it.unit} - {16'd0, LowFirst});
        held = 1'b0;
        encode_point(pair);
      end else begin
        flush_held();
        if (!(({11'd0, written} + 32'd4) < {11'd0, cap_model})) begin
          stopped = 1'b1;
        end else if (it.unit >= HighFirst && it.unit <= HighLast) begin
          held_bits = it.unit[9:0];
          held = 1'b1;
        end else begin
          encode_point({16'd0, it.unit});
        end
      end
    end
    if (it.eos) begin
      flush_held();
      emit(0, 1'b1);
      held_bits = '0;
      written = '0;
      stopped = 1'b0;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  function automatic void add_item(input logic [15:0] unit, input logic valid, input logic eos);
    unit_item_t it;
    it.unit  = unit;
    it.valid = valid;
    it.eos   = eos;
    pending_units.push_back(it);
    if (valid || eos) begin
      units_made++;
    end
  endfunction

  function automatic logic [15:0] scalar_unit();
    int unsigned r;
    logic [15:0] u;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      u = 16'($urandom_range(0, 16'h7F));
    end else if (r < 6) begin
      u = 16'($urandom_range(16'h80, 16'h7FF));
    end else if (r < 9) begin
      u = 16'($urandom_range(16'h800, 16'hFFFF));
      if (u >= HighFirst && u <= LowLast) begin
        u = u ^ 16'h2000;
      end
    end else begin
      u = 16'($urandom);
    end
    return u;
  endfunction

  function automatic void add_string(input int unsigned len);
    int unsigned r;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        add_item(scalar_unit(), 1'b1, 1'b0);
      end else if (r < 85) begin
        add_item(16'($urandom_range(HighFirst, HighLast)), 1'b1, 1'b0);
        add_item(16'($urandom_range(LowFirst, LowLast)), 1'b1, 1'b0);
      end else if (r < 90) begin
        add_item(16'($urandom_range(HighFirst, HighLast)), 1'b1, 1'b0);
      end else if (r < 95) begin
        add_item(16'($urandom_range(LowFirst, LowLast)), 1'b1, 1'b0);
      end else begin
        add_item(16'($urandom), 1'b0, 1'b0);
      end
    end
    if (len == 0 || $urandom_range(0, 3) == 0) begin
      add_item(16'($urandom), 1'b0, 1'b1);
    end else begin
      pending_units[$].eos = 1'b1;
    end
  endfunction

  function automatic void add_strings(input int unsigned count, input int unsigned longest);
    int unsigned goal;
    goal = units_made + count;
    while (units_made < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        add_string($urandom_range(20, 40));
      end else begin
        add_string($urandom_range(0, longest));
      end
    end
  endfunction

  task automatic wait_idle();
    while (pending_units.size() != 0 || push || utf8_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CapW-1:0] value);
    @(negedge clk_i);
    out_capacity_i    <= value;
    out_capacity_we_i <= 1'b1;
    @(negedge clk_i);
    out_capacity_we_i <= 1'b0;
    cap_model = value;
  endtask

  task automatic run_phase(input logic [CapW-1:0] value, input int unsigned count,
                           input int unsigned longest, input logic calm);
    set_capacity(value);
    steady = calm;
    add_strings(count, longest);
    wait_idle();
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (push && !took) begin
      push <= 1'b1;
    end else if (send_gap != 0 && !steady) begin
      push <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_units.size() != 0) begin
      code_unit_i     <= pending_units[0].unit;
      unit_valid_i    <= pending_units[0].valid;
      end_of_string_i <= pending_units[0].eos;
      void'(pending_units.pop_front());
      push     <= 1'b1;
      send_gap <= pick_gap();
    end else begin
      push <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || steady) begin
      pop <= rst_ni;
    end else if (take_stall != 0) begin
      pop <= 1'b0;
      take_stall <= take_stall - 1;
    end else begin
      pop <= 1'b1;
      take_stall <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk_i) begin
    unit_item_t it;
    utf8_byte_t want;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_ni) begin
      took = push && !full;
      if (took) begin
        it.unit  = code_unit_i;
        it.valid = unit_valid_i;
        it.eos   = end_of_string_i;
        transcode(it);
      end
      if (pop && !empty) begin
        if (utf8_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected byte %02h last %0b with nothing outstanding", out_byte_o, last_o);
          end
        end else begin
          want = utf8_expected.pop_front();
          if (out_byte_o !== want.value || last_o !== want.term) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                       want.value, want.term, out_byte_o, last_o);
            end
          end
        end
      end
    end
  end

  initial begin
    took = 1'b0;
    steady = 1'b0;
    send_gap = 0;
    take_stall = 0;
    units_made = 0;
    mismatches = 0;
    cycles = 0;
    cap_model = CapReset;
    held_bits = '0;
    held = 1'b0;
    written = '0;
    stopped = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Encoding boundaries, surrogate pairing, lone surrogates, idle and empty items.
    add_item(16'h0000, 1'b1, 1'b0);
    add_item(16'h007F, 1'b1, 1'b0);
    add_item(16'h0080, 1'b1, 1'b0);
    add_item(16'h07FF, 1'b1, 1'b0);
    add_item(16'h0800, 1'b1, 1'b0);
    add_item(16'hFFFF, 1'b1, 1'b0);
    add_item(16'hD7FF, 1'b1, 1'b1);
    add_item(HighFirst, 1'b1, 1'b0);
    add_item(LowFirst, 1'b1, 1'b0);
    add_item(HighLast, 1'b1, 1'b0);
    add_item(LowLast, 1'b1, 1'b1);
    add_item(LowFirst, 1'b1, 1'b0);
    add_item(16'hD801, 1'b1, 1'b0);
    add_item(16'h0041, 1'b1, 1'b0);
    add_item(16'hDBFE, 1'b1, 1'b0);
    add_item(HighFirst, 1'b1, 1'b0);
    add_item(16'hFFFF, 1'b0, 1'b1);
    add_item(16'hFFFF, 1'b0, 1'b0);
    add_item(16'h0000, 1'b0, 1'b1);
    add_item(16'hD912, 1'b1, 1'b1);
    add_item(16'hE000, 1'b1, 1'b1);
    wait_idle();

    run_phase(21'd0, 15, 6, 1'b0);
    run_phase(21'd1, 15, 6, 1'b0);
    run_phase(21'd4, 15, 6, 1'b1);
    run_phase(21'd5, 20, 6, 1'b0);
    run_phase(21'd6, 20, 6, 1'b0);
    run_phase(21'd7, 20, 6, 1'b0);
    run_phase(21'd256, 40, 10, 1'b1);
    run_phase(21'd256, 50, 10, 1'b0);
    run_phase(21'($urandom_range(8, 40)), 60, 12, 1'b0);
    run_phase(21'd1048576, 50, 10, 1'b0);
    run_phase(21'h1FFFFF, 50, 10, 1'b1);
    run_phase(21'($urandom_range(9, 24)), 40, 12, 1'b0);

    if (mismatches == 0 && utf8_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
